@@ rtl/utf8ws_pkg.sv @@
// Shared constants and helpers for the UTF-8 code string whitespace checker.
// Holds the verdict codes, continuation byte range classes and the whitespace table.
// No dependencies; every other file refers to it by scoped names.
package utf8ws_pkg;

    // Width of a decoded code point.
    localparam int CP_W = 21;

    // Verdict codes given on the last byte of a string.
    localparam logic [2:0] VERDICT_VALID        = 3'd0;
    localparam logic [2:0] VERDICT_BAD_UTF8     = 3'd1;
    localparam logic [2:0] VERDICT_LEADING      = 3'd2;
    localparam logic [2:0] VERDICT_OTHER_WS     = 3'd3;
    localparam logic [2:0] VERDICT_DOUBLE_SPACE = 3'd4;
    localparam logic [2:0] VERDICT_TRAILING     = 3'd5;

    // Allowed range of the next continuation byte.
    localparam logic [1:0] CLASS_PLAIN      = 2'd0;
    localparam logic [1:0] CLASS_RAISED_LO  = 2'd1;
    localparam logic [1:0] CLASS_LOWERED_HI = 2'd2;

    localparam logic [CP_W-1:0] SPACE_CP = 21'h00020;

    // True for the listed whitespace code points other than the plain space.
    function automatic logic is_other_ws(input logic [CP_W-1:0] cp);
        return cp inside {
            21'h00009, 21'h0000A, 21'h0000B, 21'h0000C, 21'h0000D, 21'h00085,
            21'h000A0, 21'h01680, 21'h0180E, 21'h02000, 21'h02001, 21'h02002,
            21'h02003, 21'h02004, 21'h02005, 21'h02006, 21'h02007, 21'h02008,
            21'h02009, 21'h0200A, 21'h0200B, 21'h0200D, 21'h02028, 21'h02029,
            21'h0202F, 21'h0205F, 21'h02063, 21'h03000, 21'h03164, 21'h0FEFF
        };
    endfunction

endpackage

@@ rtl/utf8_code_whitespace_checker_unit.sv @@
// Top level of the UTF-8 code string whitespace checker.
// Depends on utf8ws_pkg for verdict codes, range classes and the whitespace table.
// Holds the input register, decode and check logic, string state and result register.
//
//  Channel  | Handshake                 | Payload
//  ---------+---------------------------+------------------------------
//  input    | in_valid / in_stall       | text_byte[7:0], end_of_string
//  result   | out_valid / out_stall     | verdict[2:0]
//
// One byte enters per cycle unless stalled; a verdict registers as its last byte moves on.
// Throughput is set by the string state registers, updated once per byte in one pass.
// A stalled result holds the input register only when it carries a last byte.
// Reset clears the string state and both valid flags; no clearing pass is needed.
module utf8_code_whitespace_checker_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] text_byte,
    input  logic       end_of_string,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] verdict
);

    // Input register.
    logic       in_valid_reg;
    logic [7:0] byte_reg;
    logic       eos_reg;

    // String state.
    logic [1:0]                   pending_reg,  pending_next;
    logic [utf8ws_pkg::CP_W-1:0]  partial_reg,  partial_next;
    logic [1:0]                   class_reg,    class_next;
    logic [1:0]                   run_reg,      run_next;
    logic                         seen_reg,     seen_next;
    logic [2:0]                   error_reg,    error_next;

    // Result register.
    logic       out_valid_reg;
    logic [2:0] verdict_reg;
    logic [2:0] verdict_next;

    // Decode scratch.
    logic                         cp_done;
    logic [utf8ws_pkg::CP_W-1:0]  cp_value;
    logic [7:0]                   range_lo;
    logic [7:0]                   range_hi;
    logic [1:0]                   pending_dec;
    logic [1:0]                   run_upd;

    logic advance;
    logic in_xfer;
    logic out_xfer;

    // The held byte moves on unless it closes a string and the result slot is blocked.
    assign advance  = in_valid_reg && (!eos_reg || !out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign in_xfer  = in_valid && !in_stall;
    assign out_xfer = out_valid_reg && !out_stall;

    assign out_valid = out_valid_reg;
    assign verdict   = verdict_reg;

    // Continuation byte bounds for the current class.
    always_comb
    begin
        range_lo = 8'h80;
        range_hi = 8'hBF;
        if (class_reg == utf8ws_pkg::CLASS_RAISED_LO)
        begin
            range_lo = (pending_reg == 2'd3) ? 8'h90 : 8'hA0;
        end
        else if (class_reg == utf8ws_pkg::CLASS_LOWERED_HI)
        begin
            range_hi = (pending_reg == 2'd3) ? 8'h8F : 8'h9F;
        end
    end

    // Byte decode, code point checks and verdict for one held byte.
    always_comb
    begin
        pending_next = pending_reg;
        partial_next = partial_reg;
        class_next   = class_reg;
        run_next     = run_reg;
        seen_next    = seen_reg;
        error_next   = error_reg;
        cp_done      = 1'b0;
        cp_value     = partial_reg;
        pending_dec  = pending_reg - 2'd1;
        run_upd      = 2'd0;
        verdict_next = utf8ws_pkg::VERDICT_VALID;

        // Decode, skipped once an error has been latched.
        if (error_reg == utf8ws_pkg::VERDICT_VALID)
        begin
            if (pending_reg == 2'd0)
            begin
                if (byte_reg < 8'h80)
                begin
                    cp_done  = 1'b1;
                    cp_value = {13'd0, byte_reg};
                end
                else if (byte_reg inside {[8'hC2:8'hDF]})
                begin
                    pending_next = 2'd1;
                    partial_next = {16'd0, byte_reg[4:0]};
                    class_next   = utf8ws_pkg::CLASS_PLAIN;
                end
                else if (byte_reg inside {[8'hE0:8'hEF]})
                begin
                    pending_next = 2'd2;
                    partial_next = {17'd0, byte_reg[3:0]};
                    if (byte_reg == 8'hE0)
                        class_next = utf8ws_pkg::CLASS_RAISED_LO;
                    else if (byte_reg == 8'hED)
                        class_next = utf8ws_pkg::CLASS_LOWERED_HI;
                    else
                        class_next = utf8ws_pkg::CLASS_PLAIN;
                end
                else if (byte_reg inside {[8'hF0:8'hF4]})
                begin
                    pending_next = 2'd3;
                    partial_next = {18'd0, byte_reg[2:0]};
                    if (byte_reg == 8'hF0)
                        class_next = utf8ws_pkg::CLASS_RAISED_LO;
                    else if (byte_reg == 8'hF4)
                        class_next = utf8ws_pkg::CLASS_LOWERED_HI;
                    else
                        class_next = utf8ws_pkg::CLASS_PLAIN;
                end
                else
                begin
                    error_next = utf8ws_pkg::VERDICT_BAD_UTF8;
                end
            end
            else if (byte_reg < range_lo || byte_reg > range_hi)
            begin
                error_next = utf8ws_pkg::VERDICT_BAD_UTF8;
            end
            else
            begin
                partial_next = {partial_reg[14:0], byte_reg[5:0]};
                pending_next = pending_dec;
                class_next   = utf8ws_pkg::CLASS_PLAIN;
                cp_done      = (pending_dec == 2'd0);
                cp_value     = {partial_reg[14:0], byte_reg[5:0]};
            end
        end

        // Whitespace rules on a completed code point, first failing rule wins.
        if (cp_done)
        begin
            if (cp_value == utf8ws_pkg::SPACE_CP)
                run_upd = (run_reg == 2'd2) ? 2'd2 : run_reg + 2'd1;
            else
                run_upd = 2'd0;
            run_next = run_upd;
            if (run_upd != 2'd0 && !seen_reg)
            begin
                error_next = utf8ws_pkg::VERDICT_LEADING;
            end
            else if (utf8ws_pkg::is_other_ws(cp_value))
            begin
                error_next = utf8ws_pkg::VERDICT_OTHER_WS;
            end
            else
            begin
                seen_next = 1'b1;
                if (run_upd == 2'd2)
                    error_next = utf8ws_pkg::VERDICT_DOUBLE_SPACE;
            end
        end

        // Last byte: give the verdict and start a fresh string.
        if (eos_reg)
        begin
            if (error_next != utf8ws_pkg::VERDICT_VALID)
                verdict_next = error_next;
            else if (pending_next != 2'd0)
                verdict_next = utf8ws_pkg::VERDICT_BAD_UTF8;
            else if (run_next != 2'd0)
                verdict_next = utf8ws_pkg::VERDICT_TRAILING;
            else
                verdict_next = utf8ws_pkg::VERDICT_VALID;
            pending_next = 2'd0;
            partial_next = '0;
            class_next   = utf8ws_pkg::CLASS_PLAIN;
            run_next     = 2'd0;
            seen_next    = 1'b0;
            error_next   = utf8ws_pkg::VERDICT_VALID;
        end
    end

    // Input register: refills whenever the held byte moves on or the slot is empty.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            byte_reg <= text_byte;
            eos_reg  <= end_of_string;
        end
    end

    // String state update, one byte per cycle while the held byte moves on.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 2'd0;
            partial_reg <= '0;
            class_reg   <= utf8ws_pkg::CLASS_PLAIN;
            run_reg     <= 2'd0;
            seen_reg    <= 1'b0;
            error_reg   <= utf8ws_pkg::VERDICT_VALID;
        end
        else if (advance)
        begin
            pending_reg <= pending_next;
            partial_reg <= partial_next;
            class_reg   <= class_next;
            run_reg     <= run_next;
            seen_reg    <= seen_next;
            error_reg   <= error_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && eos_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_xfer)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && eos_reg)
        begin
            verdict_reg <= verdict_next;
        end
    end

    // A last byte that moves on always leaves a verdict waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && eos_reg) |=> out_valid_reg)
        else $error("verdict lost after last byte");

    // With no continuation pending the range class is plain.
    assert property (@(posedge clk) disable iff (!rst_n)
        (pending_reg == 2'd0) |-> (class_reg == utf8ws_pkg::CLASS_PLAIN))
        else $error("range class set with nothing pending");

    // A space run before any other character must have latched an error.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!seen_reg && error_reg == utf8ws_pkg::VERDICT_VALID) |-> (run_reg == 2'd0))
        else $error("leading space not flagged");

    // The space run saturates at two and latched errors stay within the codes.
    assert property (@(posedge clk) disable iff (!rst_n)
        (run_reg != 2'd3) && (error_reg <= utf8ws_pkg::VERDICT_TRAILING))
        else $error("string state out of range");

    // The input side stalls only while a byte is held.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (in_valid_reg && eos_reg && out_valid_reg))
        else $error("input stalled without cause");

endmodule
